// File: rtl/plain_bitmap_to_printer_lines_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap line packer
// Immediate-implication and next-cycle implication forms, clocked and reset
// gated.
// ----------------------------------------------------------------------------
`ifndef PLAIN_BITMAP_TO_PRINTER_LINES_UNIT_DEFINES_SVH
`define PLAIN_BITMAP_TO_PRINTER_LINES_UNIT_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define PBPL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the following cycle
`define PBPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pbpl_pkg.sv
// ----------------------------------------------------------------------------
// pbpl_pkg
// Constants shared by the bitmap-to-printer line packer.
// ----------------------------------------------------------------------------
`default_nettype none

package pbpl_pkg;

  localparam int MAX_LINE_PIXELS = 448;

  localparam int LW_W   = 9;
  localparam int IW_W   = 12;
  localparam int IH_W   = 12;
  localparam int LH_W   = 13;
  localparam int CFG_W  = 13;
  localparam int CIDX_W = 2;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_LABEL_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CIDX_W-1:0] REG_LABEL_HEIGHT = 2'd3;

  localparam logic [LW_W-1:0] LABEL_WIDTH_RST  = 9'd192;
  localparam logic [IW_W-1:0] IMAGE_WIDTH_RST  = 12'd192;
  localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = 12'd4095;
  localparam logic [LH_W-1:0] LABEL_HEIGHT_RST = 13'd600;

  // printer command bytes and pixel characters
  localparam logic [7:0] ESC_CODE = 8'd27;
  localparam logic [7:0] SYN_CODE = 8'h16;
  localparam logic [7:0] CMD_LINE = 8'h44;  // 'D'
  localparam logic [7:0] CMD_FEED = 8'h45;  // 'E'
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] TOP_BIT  = 8'h80;

endpackage

`default_nettype wire

// File: rtl/plain_bitmap_to_printer_lines_unit.sv
// ----------------------------------------------------------------------------
// plain_bitmap_to_printer_lines_unit
// Packs plain bitmap body characters into printhead lines held in a line
// memory and emits the printer command stream for each finished row.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_char_in, in_end_of_input
//  out     | output    | out_valid / out_ready| out_byte, out_last_of_run
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A character that does not finish a row or the page keeps input ready; pixels stream at
//  one per cycle through a read-modify-write of the line memory with forwarding.
//  A finished row holds off input while the header is sent, each line byte is read
//  from memory and then loaded for output, and a form feed is sent if due; output stalls can lengthen this.
//  Reset is synchronous; line memory entries carry valid bits, so no clearing
//  pass is needed after reset or after a line. Output stalls hold the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "plain_bitmap_to_printer_lines_unit_defines.svh"

module plain_bitmap_to_printer_lines_unit #(
  parameter int MAX_LINE_PIXELS = pbpl_pkg::MAX_LINE_PIXELS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [7:0]                  in_char_in,
  input  wire logic                        in_end_of_input,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [7:0]                  out_byte,
  output      logic                        out_last_of_run,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [pbpl_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [pbpl_pkg::CFG_W-1:0]  cfg_data
);

  localparam int STORE_BYTES = (MAX_LINE_PIXELS + 7) / 8;
  localparam int IDX_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CNT_W       = $clog2(STORE_BYTES + 1);
  localparam logic [pbpl_pkg::LW_W-1:0] MAX_PIX = pbpl_pkg::LW_W'(MAX_LINE_PIXELS);

  typedef enum logic [2:0] {S_IDLE, S_HDR, S_RD, S_LD, S_FF} state_t;

  // configuration
  logic [pbpl_pkg::LW_W-1:0] label_width_r;
  logic [pbpl_pkg::IW_W-1:0] image_width_r;
  logic [pbpl_pkg::IH_W-1:0] image_height_r;
  logic [pbpl_pkg::LH_W-1:0] label_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_width_r  <= pbpl_pkg::LABEL_WIDTH_RST;
      image_width_r  <= pbpl_pkg::IMAGE_WIDTH_RST;
      image_height_r <= pbpl_pkg::IMAGE_HEIGHT_RST;
      label_height_r <= pbpl_pkg::LABEL_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbpl_pkg::REG_LABEL_WIDTH:  label_width_r  <= cfg_data[pbpl_pkg::LW_W-1:0];
        pbpl_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[pbpl_pkg::IW_W-1:0];
        pbpl_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[pbpl_pkg::IH_W-1:0];
        pbpl_pkg::REG_LABEL_HEIGHT: label_height_r <= cfg_data[pbpl_pkg::LH_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t                    state_r;
  logic [11:0]               pos_r;
  logic [12:0]               lines_done_r;
  logic                      page_fin_r;
  logic                      ff_pend_r;
  logic [CNT_W-1:0]          nbytes_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [1:0]                hcnt_r;
  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic                      out_last_r;

  // derived configuration
  logic [pbpl_pkg::LW_W-1:0] width;
  logic [9:0]                width_sum;
  logic [CNT_W-1:0]          nbytes;
  logic [11:0]               row;
  logic [12:0]               limit;
  logic [12:0]               next_pos;
  logic [12:0]               ld_inc;
  logic [11:0]               pos_byte;
  logic                      in_acc;
  logic                      is_pix;
  logic                      pix_wr;
  logic                      row_done;
  logic                      slot_free;
  logic                      out_load;
  logic [CNT_W-1:0]          cnt_inc;
  logic                      cnt_last;
  logic                      vld_clr;

  always_comb begin
    width     = (label_width_r > MAX_PIX) ? MAX_PIX : label_width_r;
    width_sum = {1'b0, width} + 10'd7;
    nbytes    = CNT_W'(width_sum >> 3);
    row       = (image_width_r == '0) ? 12'd1 : image_width_r;
    limit     = ({1'b0, image_height_r} < label_height_r) ? {1'b0, image_height_r}
                                                          : label_height_r;
    next_pos  = {1'b0, pos_r} + 13'd1;
    ld_inc    = lines_done_r + 13'd1;
    pos_byte  = pos_r >> 3;
    in_acc    = in_valid && in_ready;
    is_pix    = (in_char_in == pbpl_pkg::CH_ONE) || (in_char_in == pbpl_pkg::CH_ZERO);
    row_done  = next_pos >= {1'b0, row};
    pix_wr    = in_acc && !page_fin_r && !in_end_of_input && (lines_done_r < limit) &&
                is_pix && ({3'b0, width} > pos_r);
    slot_free = !out_valid_r || out_ready;
    out_load  = slot_free && (state_r inside {S_HDR, S_LD, S_FF});
    cnt_inc   = cnt_r + 1'b1;
    cnt_last  = (cnt_inc == nbytes_r);
    vld_clr   = slot_free && (((state_r == S_HDR) && (hcnt_r == 2'd3) && (nbytes_r == '0)) ||
                              ((state_r == S_LD) && cnt_last));
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  // line memory with per-entry valid bits; read data registered
  logic [7:0]             mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] vld_r;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_ra;
  logic [7:0]             rd_data_r;
  logic                   rd_vld_r;

  // pixel write stage and last-write forwarding
  logic                   s1_v_r;
  logic [IDX_W-1:0]       s1_idx_r;
  logic [2:0]             s1_bit_r;
  logic                   s1_one_r;
  logic                   lastw_v_r;
  logic [IDX_W-1:0]       lastw_idx_r;
  logic [7:0]             lastw_data_r;
  logic [7:0]             wr_base;
  logic [7:0]             wr_mask;
  logic [7:0]             wr_data;

  always_comb begin
    mem_re = pix_wr || (state_r == S_RD);
    mem_ra = (state_r == S_RD) ? cnt_r[IDX_W-1:0] : pos_byte[IDX_W-1:0];
    if (lastw_v_r && (lastw_idx_r == s1_idx_r)) begin
      wr_base = lastw_data_r;
    end else begin
      wr_base = rd_vld_r ? rd_data_r : 8'h00;
    end
    wr_mask = pbpl_pkg::TOP_BIT >> s1_bit_r;
    wr_data = s1_one_r ? (wr_base | wr_mask) : (wr_base & ~wr_mask);
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      mem[s1_idx_r] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
      rd_vld_r  <= vld_r[mem_ra];
    end
    s1_idx_r     <= pos_byte[IDX_W-1:0];
    s1_bit_r     <= pos_r[2:0];
    s1_one_r     <= (in_char_in == pbpl_pkg::CH_ONE);
    lastw_idx_r  <= s1_idx_r;
    lastw_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      s1_v_r    <= 1'b0;
      lastw_v_r <= 1'b0;
    end else begin
      s1_v_r    <= pix_wr;
      lastw_v_r <= s1_v_r;
      if (vld_clr) begin
        vld_r <= '0;
      end else if (s1_v_r) begin
        vld_r[s1_idx_r] <= 1'b1;
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      lines_done_r <= '0;
      page_fin_r   <= 1'b0;
      ff_pend_r    <= 1'b0;
      nbytes_r     <= '0;
      cnt_r        <= '0;
      hcnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && !page_fin_r) begin
            if (in_end_of_input || (lines_done_r >= limit)) begin
              page_fin_r <= 1'b1;
              hcnt_r     <= '0;
              state_r    <= S_FF;
              if (in_end_of_input) begin
                pos_r <= '0;
              end
            end else if (is_pix) begin
              if (row_done) begin
                pos_r        <= '0;
                lines_done_r <= ld_inc;
                ff_pend_r    <= (ld_inc >= limit);
                page_fin_r   <= (ld_inc >= limit);
                nbytes_r     <= nbytes;
                hcnt_r       <= '0;
                cnt_r        <= '0;
                state_r      <= S_HDR;
              end else begin
                pos_r <= next_pos[11:0];
              end
            end
          end
        end
        S_HDR: begin
          if (slot_free) begin
            out_last_r  <= 1'b0;
            case (hcnt_r)
              2'd0: out_byte_r <= pbpl_pkg::ESC_CODE;
              2'd1: out_byte_r <= pbpl_pkg::CMD_LINE;
              2'd2: out_byte_r <= 8'(nbytes_r);
              default: begin
                out_byte_r <= pbpl_pkg::SYN_CODE;
                out_last_r <= (nbytes_r == '0) && !ff_pend_r;
              end
            endcase
            hcnt_r <= hcnt_r + 2'd1;
            if (hcnt_r == 2'd3) begin
              if (nbytes_r == '0) begin
                state_r <= ff_pend_r ? S_FF : S_IDLE;
              end else begin
                state_r <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          state_r <= S_LD;
        end
        S_LD: begin
          if (slot_free) begin
            out_byte_r  <= rd_vld_r ? rd_data_r : 8'h00;
            out_last_r  <= cnt_last && !ff_pend_r;
            if (cnt_last) begin
              cnt_r   <= '0;
              hcnt_r  <= '0;
              state_r <= ff_pend_r ? S_FF : S_IDLE;
            end else begin
              cnt_r   <= cnt_inc;
              state_r <= S_RD;
            end
          end
        end
        S_FF: begin
          if (slot_free) begin
            out_byte_r  <= (hcnt_r == 2'd0) ? pbpl_pkg::ESC_CODE : pbpl_pkg::CMD_FEED;
            out_last_r  <= (hcnt_r != 2'd0);
            hcnt_r      <= hcnt_r + 2'd1;
            if (hcnt_r != 2'd0) begin
              ff_pend_r <= 1'b0;
              state_r   <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a pixel write never lands in the cycle the line valid bits are dropped
  `PBPL_ASSERT_SAME(a_no_wr_on_clr, clk, rst_n, vld_clr, !s1_v_r, "pixel write races line clear")
  // the sweep stays inside the line
  `PBPL_ASSERT_SAME(a_sweep_bound, clk, rst_n, state_r == S_LD || state_r == S_RD,
                    cnt_r < nbytes_r, "line sweep index past byte count")
  // a pixel write only follows an accepted transaction
  `PBPL_ASSERT_SAME(a_wr_after_acc, clk, rst_n, s1_v_r, $past(in_valid && in_ready),
                    "pixel write without input transaction")
  // once the page is done no further pixel writes are started
  `PBPL_ASSERT_NEXT(a_page_quiet, clk, rst_n, page_fin_r && $past(page_fin_r), !s1_v_r,
                    "pixel write after page finished")

endmodule

`default_nettype wire
